// ===== rtl/rst_pkg.sv =====
package rst_pkg;
  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);

  typedef enum logic [2:0] {
    ACT_CLEAR  = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_LOOKUP = 3'd3,
    ACT_SORT   = 3'd4
  } action_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SORT, S_DONE
  } state_t;

  typedef struct packed {
    logic load;       // latch request
    logic scan_clr;   // reset scan index
    logic scan_step;  // advance scan index
    logic sort_step;  // compare/swap pair at index
    logic pass_clr;   // clear swap flag
    logic commit;     // apply the action result
    logic clear_all;  // drop all valid marks
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       hit;       // current slot satisfies scan condition
    logic       last;      // index at final slot (scan) or final pair (sort)
    logic       swapped;   // a swap happened in this pass
  } sts_t;
endpackage

// ===== rtl/record_slot_table.sv =====
// record_slot_table: record slots with first-free insert and bubble sort.
// Sequencing: clear/other commit straight from the scan state; insert/delete/lookup scan
//   one slot per cycle and stop at a hit; sort compares each adjacent pair per pass until a clean pass.
// Throughput: one request at a time; busy stays high through the result cycle, so the
//   next request is taken in the cycle after out_valid at the earliest. No receiver stall.
// Reset (rst_n low, synchronous): all slots empty, id counter zero, controller idle.
module record_slot_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [15:0] in_record_id,
  input  logic [63:0] in_name_key,
  input  logic [63:0] in_surname,
  input  logic [28:0] in_amount,
  input  logic        in_kind,
  input  logic        in_ascending,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot_index,
  output logic [15:0] out_assigned_id
);
  import rst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: sequence scan, sort passes and result strobe.
  rst_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts),
    .cmd(cmd), .busy(busy), .done(out_valid)
  );

  // Datapath: slot storage, scan index, compare/swap and result registers.
  rst_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_action(in_action), .in_record_id(in_record_id), .in_name_key(in_name_key),
    .in_surname(in_surname), .in_amount(in_amount), .in_kind(in_kind),
    .in_ascending(in_ascending),
    .res_status(out_status), .res_slot(out_slot_index), .res_id(out_assigned_id)
  );
endmodule

// ===== rtl/rst_ctrl.sv =====
module rst_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  rst_pkg::sts_t sts,
  output rst_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done
);
  import rst_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != S_IDLE);
    done = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          cmd.scan_clr = 1'b1;
          cmd.pass_clr = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (sts.action == ACT_SORT) begin
          state_nxt = S_SORT;
        end else if (sts.action == ACT_INSERT || sts.action == ACT_DELETE ||
                     sts.action == ACT_LOOKUP) begin
          if (sts.hit || sts.last) begin
            cmd.commit = 1'b1;
            state_nxt = S_DONE;
          end else begin
            cmd.scan_step = 1'b1;
          end
        end else begin
          cmd.clear_all = (sts.action == ACT_CLEAR);
          cmd.commit = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_SORT: begin
        cmd.sort_step = 1'b1;
        if (sts.last) begin
          cmd.scan_clr = 1'b1;
          cmd.pass_clr = 1'b1;
          if (!sts.swapped && !sts.hit) begin
            cmd.commit = 1'b1;
            state_nxt = S_DONE;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_DONE: begin
        done = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== rtl/rst_datapath.sv =====
module rst_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rst_pkg::cmd_t        cmd,
  output rst_pkg::sts_t        sts,
  input  logic [2:0]           in_action,
  input  logic [15:0]          in_record_id,
  input  logic [63:0]          in_name_key,
  input  logic [63:0]          in_surname,
  input  logic [28:0]          in_amount,
  input  logic                 in_kind,
  input  logic                 in_ascending,
  output logic [1:0]           res_status,
  output logic [3:0]           res_slot,
  output logic [15:0]          res_id
);
  import rst_pkg::*;

  logic [SLOTS-1:0] valid_r;
  logic [15:0] id_r      [SLOTS];
  logic [63:0] name_r    [SLOTS];
  logic [63:0] sur_r     [SLOTS];
  logic [28:0] amt_r     [SLOTS];
  logic        kind_r    [SLOTS];
  logic [15:0] next_id_r;

  logic [2:0]  act_r;
  logic [15:0] rid_r;
  logic [63:0] nk_r, sn_r;
  logic [28:0] am_r;
  logic        kd_r, asc_r;
  logic [IDX_W-1:0] idx_r;
  logic        swp_r;
  logic [1:0]  st_r;
  logic [3:0]  sl_r;
  logic [15:0] aid_r;

  logic [IDX_W-1:0] idx1;
  logic hit, do_swap;
  assign idx1 = idx_r + 1'b1;

  always_comb begin
    if (act_r == ACT_INSERT) hit = !valid_r[idx_r];
    else                     hit = valid_r[idx_r] && (id_r[idx_r] == rid_r);
    do_swap = valid_r[idx_r] && valid_r[idx1] &&
              (asc_r ? (name_r[idx_r] > name_r[idx1])
                     : (name_r[idx_r] < name_r[idx1]));
  end

  assign sts.action  = act_r;
  assign sts.hit     = (act_r == ACT_SORT) ? do_swap : hit;
  assign sts.last    = (act_r == ACT_SORT) ? (idx_r == IDX_W'(SLOTS - 2))
                                           : (idx_r == IDX_W'(SLOTS - 1));
  assign sts.swapped = swp_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action; rid_r <= in_record_id; nk_r <= in_name_key;
      sn_r <= in_surname; am_r <= in_amount; kd_r <= in_kind; asc_r <= in_ascending;
    end
    if (cmd.scan_clr)       idx_r <= '0;
    else if (cmd.scan_step) idx_r <= idx1;
    if (cmd.pass_clr)       swp_r <= 1'b0;
    else if (cmd.sort_step && do_swap) swp_r <= 1'b1;
    if (cmd.sort_step && do_swap) begin
      id_r[idx_r] <= id_r[idx1];     id_r[idx1] <= id_r[idx_r];
      name_r[idx_r] <= name_r[idx1]; name_r[idx1] <= name_r[idx_r];
      sur_r[idx_r] <= sur_r[idx1];   sur_r[idx1] <= sur_r[idx_r];
      amt_r[idx_r] <= amt_r[idx1];   amt_r[idx1] <= amt_r[idx_r];
      kind_r[idx_r] <= kind_r[idx1]; kind_r[idx1] <= kind_r[idx_r];
    end
    if (cmd.commit) begin
      if (act_r == ACT_INSERT && hit) begin
        name_r[idx_r] <= nk_r; sur_r[idx_r] <= sn_r; amt_r[idx_r] <= am_r;
        kind_r[idx_r] <= kd_r; id_r[idx_r] <= next_id_r;
        st_r <= ST_OK; aid_r <= next_id_r; sl_r <= 4'(idx_r);
      end else if (act_r == ACT_INSERT) begin
        st_r <= ST_FULL; sl_r <= '0; aid_r <= '0;
      end else if ((act_r == ACT_DELETE || act_r == ACT_LOOKUP) && hit) begin
        st_r <= ST_OK; sl_r <= 4'(idx_r); aid_r <= '0;
      end else if (act_r == ACT_DELETE || act_r == ACT_LOOKUP) begin
        st_r <= ST_NOTFOUND; sl_r <= '0; aid_r <= '0;
      end else begin
        st_r <= ST_OK; sl_r <= '0; aid_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      next_id_r <= '0;
    end else begin
      if (cmd.clear_all) valid_r <= '0;
      if (cmd.commit && hit) begin
        if (act_r == ACT_INSERT) begin
          valid_r[idx_r] <= 1'b1;
          next_id_r <= next_id_r + 16'd1;
        end else if (act_r == ACT_DELETE) begin
          valid_r[idx_r] <= 1'b0;
        end
      end
    end
  end

  assign res_status = st_r;
  assign res_slot   = sl_r;
  assign res_id     = aid_r;
endmodule
